// ===== hdl/rlec_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types of the coalescer.
`default_nettype none

package rlec_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int TIME_WIDTH_DEF   = 32;

	// Field and register widths.
	localparam int TAG_W      = 32;
	localparam int CNT_W      = 16;
	localparam int WL_W       = 16;
	localparam int RL_W       = 7;
	localparam int GD_W       = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_DELAY   = 2'd2;

	// Register values after reset.
	localparam logic [WL_W-1:0] WINDOW_LENGTH_RST = 16'd60;
	localparam logic [RL_W-1:0] RATE_LIMIT_RST    = 7'd10;
	localparam logic [GD_W-1:0] GROUP_DELAY_RST   = 16'd30;

	// Input command and result kind codes.
	localparam logic CMD_MESSAGE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;
	localparam logic KIND_PASS   = 1'b0;
	localparam logic KIND_GROUP  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;     // input transfer taken this cycle
		logic store_stamp; // record the current time in the ring
		logic emit_pass;   // load a pass-through result
		logic hold_msg;    // count the message as pending, enter congestion
		logic pop;         // drop the oldest stamp
		logic emit_grp;    // load a deadline summary and re-arm the deadline
		logic emit_fin;    // load a final summary and leave congestion
		logic last;        // last flag of the result loaded this cycle
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_tick;      // command of the offered input item is a tick
		logic out_free;     // output register can take a result this cycle
		logic pass_ok;      // a stored message would pass straight through
		logic expired;      // oldest stamp has left the window
		logic congested;    // congestion mode
		logic deadline_hit; // flush deadline reached
		logic rate_low;     // window count below the limit
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rlec_dp.sv =====
// Datapath of the coalescer: configuration, stamp ring, window state and output register.
`default_nettype none

module rlec_dp #(
	parameter int WINDOW_DEPTH = rlec_pkg::WINDOW_DEPTH_DEF,
	parameter int TIME_WIDTH   = rlec_pkg::TIME_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [rlec_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [rlec_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              cmd,
	input  wire  [rlec_pkg::TAG_W-1:0]       msg_tag,
	input  wire  rlec_pkg::ctrl_cmd_t        ctl,
	output rlec_pkg::dp_stat_t               stat,
	output logic                             res_valid,
	input  wire                              res_ready,
	output logic                             kind,
	output logic [rlec_pkg::TAG_W-1:0]       pass_tag,
	output logic [rlec_pkg::CNT_W-1:0]       group_count,
	output logic                             last
);

	localparam int HW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = FW + 1;
	localparam int CW = (FW > rlec_pkg::RL_W) ? FW : rlec_pkg::RL_W;

	logic [rlec_pkg::WL_W-1:0]  window_length_q;
	logic [rlec_pkg::RL_W-1:0]  rate_limit_q;
	logic [rlec_pkg::GD_W-1:0]  group_delay_q;

	logic [TIME_WIDTH-1:0]      ring_mem [WINDOW_DEPTH];
	logic [TIME_WIDTH-1:0]      rd_data_q;
	logic [HW-1:0]              head_q;
	logic [FW-1:0]              fill_q;
	logic [TIME_WIDTH-1:0]      now_q;
	logic [TIME_WIDTH-1:0]      deadline_q;
	logic                       congested_q;
	logic [rlec_pkg::CNT_W-1:0] pending_q;
	logic [rlec_pkg::TAG_W-1:0] tag_q;

	logic                       res_valid_q;
	logic                       kind_q;
	logic [rlec_pkg::TAG_W-1:0] pass_tag_q;
	logic [rlec_pkg::CNT_W-1:0] group_count_q;
	logic                       last_q;

	logic [HW-1:0]         head_inc;
	logic [SW-1:0]         slot_sum;
	logic [HW-1:0]         slot;
	logic                  ring_full;
	logic [HW-1:0]         wr_addr;
	logic [HW-1:0]         rd_addr;
	logic [FW-1:0]         fill_new;
	logic [TIME_WIDTH-1:0] age;
	logic [TIME_WIDTH-1:0] deadline_diff;
	logic [TIME_WIDTH-1:0] next_deadline;
	logic                  emit_any;

	// Ring addressing: the next slot wraps at the ring depth.
	assign head_inc  = (head_q == HW'(WINDOW_DEPTH - 1)) ? '0 : head_q + HW'(1);
	assign slot_sum  = SW'(head_q) + SW'(fill_q);
	assign slot      = (slot_sum >= SW'(WINDOW_DEPTH)) ? HW'(slot_sum - SW'(WINDOW_DEPTH))
	                                                   : HW'(slot_sum);
	assign ring_full = (fill_q == FW'(WINDOW_DEPTH));
	assign wr_addr   = ring_full ? head_q : slot;
	assign rd_addr   = ctl.pop ? head_inc : head_q;
	assign fill_new  = ring_full ? fill_q : fill_q + FW'(1);

	// Window and deadline comparisons; all time arithmetic wraps.
	assign age           = now_q - rd_data_q;
	assign deadline_diff = now_q - deadline_q;
	assign next_deadline = now_q + TIME_WIDTH'(group_delay_q);
	assign emit_any      = ctl.emit_pass | ctl.emit_grp | ctl.emit_fin;

	// Status towards the controller.
	always_comb begin
		stat.in_tick      = (cmd == rlec_pkg::CMD_TICK);
		stat.out_free     = !res_valid_q || res_ready;
		stat.pass_ok      = !congested_q && (CW'(fill_new) < CW'(rate_limit_q));
		stat.expired      = (fill_q != '0) && (age > TIME_WIDTH'(window_length_q));
		stat.congested    = congested_q;
		stat.deadline_hit = !deadline_diff[TIME_WIDTH-1];
		stat.rate_low     = (CW'(fill_q) < CW'(rate_limit_q));
	end

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= rlec_pkg::WINDOW_LENGTH_RST;
			rate_limit_q    <= rlec_pkg::RATE_LIMIT_RST;
			group_delay_q   <= rlec_pkg::GROUP_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rlec_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[rlec_pkg::WL_W-1:0];
				rlec_pkg::REG_RATE_LIMIT:    rate_limit_q    <= cfg_data[rlec_pkg::RL_W-1:0];
				rlec_pkg::REG_GROUP_DELAY:   group_delay_q   <= cfg_data[rlec_pkg::GD_W-1:0];
				default: ;
			endcase
		end
	end

	// Stamp ring memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.store_stamp) begin
			ring_mem[wr_addr] <= now_q;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	// Message handle of the accepted item.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			tag_q <= msg_tag;
		end
	end

	// Ring pointers, tick clock and congestion state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			now_q       <= '0;
			deadline_q  <= '0;
			congested_q <= 1'b0;
			pending_q   <= '0;
		end else begin
			if (ctl.load_in && cmd == rlec_pkg::CMD_TICK) begin
				now_q <= now_q + TIME_WIDTH'(1);
			end
			if (ctl.store_stamp) begin
				fill_q <= fill_new;
				if (ring_full) begin
					head_q <= head_inc;
				end
			end else if (ctl.pop) begin
				head_q <= head_inc;
				fill_q <= fill_q - FW'(1);
			end
			if (ctl.hold_msg) begin
				if (!congested_q) begin
					congested_q <= 1'b1;
					deadline_q  <= next_deadline;
				end
				if (pending_q != '1) begin
					pending_q <= pending_q + rlec_pkg::CNT_W'(1);
				end
			end
			if (ctl.emit_grp) begin
				pending_q  <= '0;
				deadline_q <= next_deadline;
			end
			if (ctl.emit_fin) begin
				pending_q   <= '0;
				congested_q <= 1'b0;
			end
		end
	end

	// Output register valid flag: set on a load, cleared when the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_any) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ctl.emit_pass) begin
			kind_q        <= rlec_pkg::KIND_PASS;
			pass_tag_q    <= tag_q;
			group_count_q <= '0;
			last_q        <= ctl.last;
		end else if (ctl.emit_grp || ctl.emit_fin) begin
			kind_q        <= rlec_pkg::KIND_GROUP;
			pass_tag_q    <= '0;
			group_count_q <= pending_q;
			last_q        <= ctl.last;
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign pass_tag    = pass_tag_q;
	assign group_count = group_count_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ===== hdl/rlec_ctrl.sv =====
// Controller state machine of the coalescer: sequences message, prune and summary steps.
`default_nettype none

module rlec_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       evt_valid,
	output logic                      evt_ready,
	input  wire  rlec_pkg::dp_stat_t  stat,
	output rlec_pkg::ctrl_cmd_t       ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MSG   = 3'd1;
	localparam logic [2:0] S_PRUNE = 3'd2;
	localparam logic [2:0] S_GRP   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign evt_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		case (state_q)
			S_IDLE: begin
				if (evt_valid) begin
					ctl.load_in = 1'b1;
					state_nxt   = stat.in_tick ? S_PRUNE : S_MSG;
				end
			end
			S_MSG: begin
				// Record the stamp once the output register can take a pass-through.
				if (stat.out_free) begin
					ctl.store_stamp = 1'b1;
					if (stat.pass_ok) begin
						ctl.emit_pass = 1'b1;
						ctl.last      = 1'b1;
					end else begin
						ctl.hold_msg = 1'b1;
					end
					state_nxt = S_IDLE;
				end
			end
			S_PRUNE: begin
				// Drop one expired stamp per cycle.
				if (stat.expired) begin
					ctl.pop = 1'b1;
				end else if (stat.congested) begin
					state_nxt = S_GRP;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_GRP: begin
				if (stat.out_free) begin
					if (stat.deadline_hit) begin
						ctl.emit_grp = 1'b1;
						ctl.last     = !stat.rate_low;
						state_nxt    = stat.rate_low ? S_FIN : S_IDLE;
					end else if (stat.rate_low) begin
						ctl.emit_fin = 1'b1;
						ctl.last     = 1'b1;
						state_nxt    = S_IDLE;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_FIN: begin
				// Final summary after a deadline summary in the same tick.
				if (stat.out_free) begin
					ctl.emit_fin = 1'b1;
					ctl.last     = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rate_limit_event_coalescer.sv =====
// Top level of the rate-limiting event coalescer: controller, datapath and checks.
//
// Input channel evt_valid/evt_ready carries cmd (message or tick) and msg_tag.
// Result channel res_valid/res_ready carries kind, pass_tag, group_count and
// last; last marks the final result caused by one input item.
// Configuration: cfg_we writes cfg_data to register cfg_index (window_length,
// rate_limit, group_delay); the user must write only while the block is idle;
// the block itself does not enforce this. A message is the transfer, then the
// stamp write and decision, which loads any pass-through result into the output
// register. A tick is the transfer, then the prune step, dropping expired stamps
// one per cycle through the stamp memory's registered read port; a congested tick
// then takes a summary step, and a final-summary step when it gives two summaries.
// Reset clears the window state and loads the register defaults; the stamp
// memory needs no clearing, as only filled entries are read.
// A result waits in the output register while the receiver stalls; the next
// input is still taken, but a message or a congested tick then waits in its
// decision cycle until the output register is free.
`default_nettype none

module rate_limit_event_coalescer #(
	parameter int WINDOW_DEPTH = rlec_pkg::WINDOW_DEPTH_DEF,
	parameter int TIME_WIDTH   = rlec_pkg::TIME_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [rlec_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [rlec_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              evt_valid,
	output logic                             evt_ready,
	input  wire                              cmd,
	input  wire  [rlec_pkg::TAG_W-1:0]       msg_tag,
	output logic                             res_valid,
	input  wire                              res_ready,
	output logic                             kind,
	output logic [rlec_pkg::TAG_W-1:0]       pass_tag,
	output logic [rlec_pkg::CNT_W-1:0]       group_count,
	output logic                             last
);

	rlec_pkg::ctrl_cmd_t ctl;
	rlec_pkg::dp_stat_t  stat;

	rlec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	rlec_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.msg_tag     (msg_tag),
		.ctl         (ctl),
		.stat        (stat),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.kind        (kind),
		.pass_tag    (pass_tag),
		.group_count (group_count),
		.last        (last)
	);

	// At most one of the exclusive datapath actions happens in a cycle.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load_in, ctl.pop, ctl.emit_pass, ctl.emit_grp, ctl.emit_fin}))
		else $error("conflicting datapath commands");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_pass || ctl.emit_grp || ctl.emit_fin) |-> stat.out_free)
		else $error("result loaded over a waiting result");

	// Only a deadline summary can be followed by another result of the same item.
	a_non_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last) |-> (kind == rlec_pkg::KIND_GROUP))
		else $error("non-final result is not a group summary");

	// A stamp is dropped only while a tick is being worked on.
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !evt_ready)
		else $error("stamp dropped while idle");

endmodule

`default_nettype wire
